// File: hw/rtl/vws_pkg.sv
// Shared types and constants for the voltammetry waveform sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package vws_pkg;

   localparam int DAC_BITS_DEFAULT = 12;

   // Field widths
   localparam int LEVEL_W   = 14;
   localparam int MV_W      = 12;
   localparam int STEP_W    = 10;
   localparam int CYCLE_W   = 8;

   // Control register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_SWEEP_MODE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LEVEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_LEVEL   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_A    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_B    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_COUNT = 3'd7;

   // Sweep modes; the unused code runs as a linear sweep
   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_CYCLIC = 2'd1;
   localparam logic [1:0] MODE_SQUARE = 2'd2;

   // Output word queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [LEVEL_W-1:0] vws_level_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [MV_W-1:0]   start_mv;
      logic signed [MV_W-1:0]   end_mv;
      logic signed [MV_W-1:0]   vertex_a_mv;
      logic signed [MV_W-1:0]   vertex_b_mv;
      logic [STEP_W-1:0]        step_mv;
      logic [STEP_W-1:0]        pulse_mv;
      logic [CYCLE_W-1:0]       cycles;
   } vws_cfg_type;

   // Words produced by one item: count 0..2, done marks the end-of-run word
   typedef struct packed {
      logic [1:0] count;
      logic       done;
   } vws_ctl_type;

   typedef struct packed {
      vws_ctl_type   ctl;
      vws_level_type level_a;
      vws_level_type level_b;
   } vws_pair_type;

endpackage

`default_nettype wire

// File: hw/rtl/voltammetry_waveform_sequencer.sv
// Top level of the voltammetry waveform sequencer: control registers, credit, wiring.
// Depends on vws_pkg, vws_seq, vws_dac and vws_queue.
//
//   channel  | ports                              | role
//   ---------+------------------------------------+----------------------------------
//   req      | req_valid req_stall req_start_req  | start a run, or one step elapsed
//   rsp      | rsp_valid rsp_stall rsp_level_mv   | applied level, DAC code, end of
//            | rsp_dac_code rsp_run_done rsp_last | run, last word of the request
//   csr      | csr_write_en csr_index             | control register writes
//            | csr_write_data                     |
//
// A request can be taken every cycle while req_stall is low. Its first word passes the
// sequencer register, then two DAC stages and the queue write, before it is visible. A
// square-wave step yields two words, so a stream of those is bounded by the single word
// per cycle the rsp side drains while rsp_stall is low. Synchronous reset clears run state
// and the queue. req_stall rises when the queue fill plus words still in flight leaves
// fewer than two free slots; rsp_stall only holds the queue head in place.
`default_nettype none

module voltammetry_waveform_sequencer #(
   parameter int DAC_BITS = vws_pkg::DAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_start_req,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vws_pkg::LEVEL_W-1:0]    rsp_level_mv,
   output logic [DAC_BITS-1:0]                   rsp_dac_code,
   output logic                                  rsp_run_done,
   output logic                                  rsp_last,
   // control registers
   input  logic                                  csr_write_en,
   input  logic [vws_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [vws_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import vws_pkg::*;

   localparam int SUM_W = QUEUE_CNT_W + 1;
   localparam logic [SUM_W-1:0] CREDIT_LIMIT = SUM_W'(QUEUE_DEPTH - 2);

   // Register values after reset: linear sweep, 1 mV step, one cycle
   localparam vws_cfg_type CFG_RESET = '{
      mode:        MODE_LINEAR,
      start_mv:    '0,
      end_mv:      '0,
      vertex_a_mv: '0,
      vertex_b_mv: '0,
      step_mv:     STEP_W'(1),
      pulse_mv:    '0,
      cycles:      CYCLE_W'(1)
   };

   vws_cfg_type cfg_ff, cfg_in;

   logic                     take;
   vws_pair_type             pair;
   vws_ctl_type              dac_ctl;
   vws_level_type [1:0]      dac_level;
   logic [1:0][DAC_BITS-1:0] dac_code;
   logic [2:0]               dac_pending;
   logic [QUEUE_CNT_W-1:0]   fill;
   logic [SUM_W-1:0]         committed;
   logic                     pop;

   // Control registers; levels and mode are read live by the sequencer
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SWEEP_MODE:  cfg_in.mode        = csr_write_data[1:0];
            CSR_START_LEVEL: cfg_in.start_mv    = csr_write_data[MV_W-1:0];
            CSR_END_LEVEL:   cfg_in.end_mv      = csr_write_data[MV_W-1:0];
            CSR_VERTEX_A:    cfg_in.vertex_a_mv = csr_write_data[MV_W-1:0];
            CSR_VERTEX_B:    cfg_in.vertex_b_mv = csr_write_data[MV_W-1:0];
            CSR_STEP:        cfg_in.step_mv     = csr_write_data[STEP_W-1:0];
            CSR_PULSE:       cfg_in.pulse_mv    = csr_write_data[STEP_W-1:0];
            CSR_CYCLE_COUNT: cfg_in.cycles      = csr_write_data[CYCLE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Credit: every word already committed (queued or in flight) holds a slot
   assign committed = SUM_W'(fill) + SUM_W'(pair.ctl.count) + SUM_W'(dac_pending);
   assign req_stall = committed > CREDIT_LIMIT;
   assign take      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   vws_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .start_req (req_start_req),
      .cfg       (cfg_ff),
      .pair_out  (pair)
   );

   vws_dac #(.DAC_BITS(DAC_BITS)) u_dac (
      .clock     (clock),
      .reset     (reset),
      .pair_in   (pair),
      .ctl_out   (dac_ctl),
      .level_out (dac_level),
      .code_out  (dac_code),
      .pending   (dac_pending)
   );

   vws_queue #(.DAC_BITS(DAC_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_ctl     (dac_ctl),
      .wr_level   (dac_level),
      .wr_code    (dac_code),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head_level (rsp_level_mv),
      .head_code  (rsp_dac_code),
      .head_done  (rsp_run_done),
      .head_last  (rsp_last),
      .fill       (fill)
   );

endmodule

`default_nettype wire

// File: hw/rtl/vws_seq.sv
// Run sequencer: holds the sweep state and turns one request into up to two levels.
// Depends on vws_pkg.
`default_nettype none

module vws_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic                 start_req,
   input  vws_pkg::vws_cfg_type cfg,
   output vws_pkg::vws_pair_type pair_out
);
   import vws_pkg::*;

   localparam logic [1:0] LEG_A   = 2'd0;
   localparam logic [1:0] LEG_B   = 2'd1;
   localparam logic [1:0] LEG_END = 2'd2;

   logic                active_ff, active_in;
   logic [1:0]          leg_ff, leg_in;
   vws_level_type       level_ff, level_in;
   logic                up_ff, up_in;
   logic [CYCLE_W-1:0]  cycles_ff, cycles_in;
   vws_pair_type        pair_ff, pair_in;

   vws_level_type st_lvl, end_lvl, va_lvl, vb_lvl;
   vws_level_type step_lvl, pulse_lvl, jump_lvl, fwd_lvl, ret_lvl, target_cur;
   logic [STEP_W:0] jump_sum;
   logic dir_a, dir_b, dir_end;
   logic go_a, go_b, go_end, go_cur, go_end_cur;
   logic [CYCLE_W-1:0] cycles_wrap;
   logic wrap_end;
   logic cy_finish, cy_up;
   logic [1:0] cy_leg;
   logic [CYCLE_W-1:0] cy_cycles;
   logic emit_step, emit_up;

   function automatic logic going(input vws_level_type lvl, input vws_level_type tgt,
                                  input logic up);
      going = up ? (lvl < tgt) : (lvl > tgt);
   endfunction

   assign st_lvl    = LEVEL_W'(cfg.start_mv);
   assign end_lvl   = LEVEL_W'(cfg.end_mv);
   assign va_lvl    = LEVEL_W'(cfg.vertex_a_mv);
   assign vb_lvl    = LEVEL_W'(cfg.vertex_b_mv);
   assign step_lvl  = $signed({{(LEVEL_W-STEP_W){1'b0}}, cfg.step_mv});
   assign pulse_lvl = $signed({{(LEVEL_W-STEP_W){1'b0}}, cfg.pulse_mv});
   assign jump_sum  = {1'b0, cfg.pulse_mv} + {1'b0, cfg.step_mv};
   assign jump_lvl  = $signed({{(LEVEL_W-STEP_W-1){1'b0}}, jump_sum});

   // Square wave: forward pulse, then back by the pulse height
   assign fwd_lvl = up_ff ? (level_ff + jump_lvl) : (level_ff - jump_lvl);
   assign ret_lvl = up_ff ? (fwd_lvl - pulse_lvl) : (fwd_lvl + pulse_lvl);

   // Leg directions as set on entry to each leg
   assign dir_a   = va_lvl > end_lvl;
   assign dir_b   = vb_lvl > va_lvl;
   assign dir_end = end_lvl > vb_lvl;
   assign go_a    = going(level_ff, va_lvl, dir_a);
   assign go_b    = going(level_ff, vb_lvl, dir_b);
   assign go_end  = going(level_ff, end_lvl, dir_end);
   assign go_end_cur = going(level_ff, end_lvl, up_ff);

   always_comb begin
      case (leg_ff)
         LEG_A:   target_cur = va_lvl;
         LEG_B:   target_cur = vb_lvl;
         default: target_cur = end_lvl;
      endcase
   end
   assign go_cur = going(level_ff, target_cur, up_ff);

   assign cycles_wrap = cycles_ff + CYCLE_W'(1);
   assign wrap_end    = (cycles_wrap == '0) || (cycles_wrap >= cfg.cycles);

   // Cyclic: finish the current leg's remainder, then later legs, then one wrap.
   // If a whole cycle after the wrap is empty, every later cycle is too.
   always_comb begin
      cy_finish = 1'b0;
      cy_leg    = leg_ff;
      cy_up     = up_ff;
      cy_cycles = cycles_ff;
      if (cycles_ff >= cfg.cycles) begin
         cy_finish = 1'b1;
      end else if (go_cur) begin
         cy_leg = leg_ff;
      end else if (leg_ff == LEG_A && go_b) begin
         cy_leg = LEG_B;
         cy_up  = dir_b;
      end else if ((leg_ff inside {LEG_A, LEG_B}) && go_end) begin
         cy_leg = LEG_END;
         cy_up  = dir_end;
      end else if (wrap_end) begin
         cy_finish = 1'b1;
      end else begin
         cy_cycles = cycles_wrap;
         if (go_a) begin
            cy_leg = LEG_A;
            cy_up  = dir_a;
         end else if (go_b) begin
            cy_leg = LEG_B;
            cy_up  = dir_b;
         end else if (go_end) begin
            cy_leg = LEG_END;
            cy_up  = dir_end;
         end else begin
            cy_finish = 1'b1;
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      leg_in    = leg_ff;
      level_in  = level_ff;
      up_in     = up_ff;
      cycles_in = cycles_ff;
      pair_in   = '0;
      emit_step = 1'b0;
      emit_up   = up_ff;
      if (take) begin
         if (start_req) begin
            active_in = 1'b1;
            leg_in    = LEG_A;
            level_in  = st_lvl;
            cycles_in = '0;
            up_in     = (cfg.mode == MODE_CYCLIC) ? (va_lvl > st_lvl) : (end_lvl > st_lvl);
            if (cfg.mode == MODE_SQUARE) begin
               pair_in.ctl.count = 2'd1;
               pair_in.level_a   = st_lvl;
            end
         end else if (active_ff) begin
            case (cfg.mode)
               MODE_SQUARE: begin
                  if (!go_end_cur) begin
                     active_in         = 1'b0;
                     pair_in.ctl.count = 2'd1;
                     pair_in.ctl.done  = 1'b1;
                  end else begin
                     pair_in.ctl.count = 2'd2;
                     pair_in.level_a   = fwd_lvl;
                     pair_in.level_b   = ret_lvl;
                     level_in          = ret_lvl;
                  end
               end
               MODE_CYCLIC: begin
                  if (cy_finish) begin
                     active_in         = 1'b0;
                     pair_in.ctl.count = 2'd1;
                     pair_in.ctl.done  = 1'b1;
                  end else begin
                     emit_step = 1'b1;
                     emit_up   = cy_up;
                     leg_in    = cy_leg;
                     up_in     = cy_up;
                     cycles_in = cy_cycles;
                  end
               end
               default: begin
                  if (!go_end_cur) begin
                     active_in         = 1'b0;
                     pair_in.ctl.count = 2'd1;
                     pair_in.ctl.done  = 1'b1;
                  end else begin
                     emit_step = 1'b1;
                  end
               end
            endcase
            if (emit_step) begin
               pair_in.ctl.count = 2'd1;
               pair_in.level_a   = level_ff;
               level_in = emit_up ? (level_ff + step_lvl) : (level_ff - step_lvl);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         leg_ff    <= LEG_A;
         level_ff  <= '0;
         up_ff     <= 1'b0;
         cycles_ff <= '0;
         pair_ff   <= '0;
      end else begin
         active_ff <= active_in;
         leg_ff    <= leg_in;
         level_ff  <= level_in;
         up_ff     <= up_in;
         cycles_ff <= cycles_in;
         pair_ff   <= pair_in;
      end
   end

   assign pair_out = pair_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vws_dac.sv
// Two-lane DAC code pipeline: level in mV to clamped DAC code, two stages.
// Depends on vws_pkg.
`default_nettype none

module vws_dac #(
   parameter int DAC_BITS = vws_pkg::DAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vws_pkg::vws_pair_type                 pair_in,
   output vws_pkg::vws_ctl_type                  ctl_out,
   output vws_pkg::vws_level_type [1:0]          level_out,
   output logic [1:0][DAC_BITS-1:0]              code_out,
   output logic [2:0]                            pending
);
   import vws_pkg::*;

   // code = floor((mv*100 + 56199) * SCALE / 33000), 33000 = 8 * 4125
   localparam int MV_GAIN   = 100;
   localparam int MV_OFFSET = 56199;
   localparam int DIV_SHIFT = 3;
   localparam int DIV_ODD   = 4125;
   localparam int DIV_TOTAL = DIV_ODD << DIV_SHIFT;

   localparam int FULL    = (1 << DAC_BITS) - 1;
   localparam int SCALE   = FULL / 5;
   localparam int M_W     = LEVEL_W + 7;
   localparam int MAG_W   = M_W - 1;
   localparam int PROD_W  = MAG_W + DAC_BITS;
   localparam int Y_W     = DAC_BITS + 13;
   localparam int SHIFT   = Y_W + 13;
   localparam int K_W     = DAC_BITS + 14;
   localparam int QP_W    = Y_W + K_W;

   localparam longint RECIP_L = ((longint'(1) << SHIFT) + DIV_ODD - 1) / DIV_ODD;
   localparam longint MLIM_L  =
      (((longint'(1) << DAC_BITS) * DIV_TOTAL) + SCALE - 1) / SCALE;

   localparam logic [K_W-1:0]      RECIP   = K_W'(RECIP_L);
   localparam logic [MAG_W-1:0]    M_LIM   = MAG_W'(MLIM_L);
   localparam logic [PROD_W-1:0]   SCALE_C = PROD_W'(SCALE);
   localparam logic [DAC_BITS-1:0] FULL_C  = DAC_BITS'(FULL);

   vws_ctl_type ctl1_ff, ctl2_ff;
   vws_level_type [1:0] level1_ff, level2_ff;
   logic [1:0][PROD_W-1:0]   prod1_ff;
   logic [1:0]               sat1_ff, zero1_ff, sat2_ff, zero2_ff;
   logic [1:0][DAC_BITS-1:0] q2_ff;

   logic [1:0][PROD_W-1:0]   prod1_in;
   logic [1:0]               sat1_in, zero1_in;
   logic [1:0][DAC_BITS-1:0] q2_in;

   for (genvar g = 0; g < 2; g++) begin : g_lane
      logic signed [M_W-1:0] mv_ext, scaled;
      logic [MAG_W-1:0]      mag;
      logic [Y_W-1:0]        y;
      logic [QP_W-1:0]       qp;

      assign mv_ext = M_W'((g == 0) ? pair_in.level_a : pair_in.level_b);
      assign scaled = mv_ext * $signed(M_W'(MV_GAIN)) + $signed(M_W'(MV_OFFSET));
      assign mag    = scaled[MAG_W-1:0];
      assign prod1_in[g] = PROD_W'(mag) * SCALE_C;
      // Beyond this limit the code clamps to full scale
      assign sat1_in[g]  = !scaled[M_W-1] && (mag >= M_LIM);
      assign zero1_in[g] = scaled[M_W-1] || ((g == 0) && pair_in.ctl.done);

      // Exact floor(y / 4125) by reciprocal for y below 2^Y_W
      assign y  = prod1_ff[g][DIV_SHIFT +: Y_W];
      assign qp = QP_W'(y) * QP_W'(RECIP);
      assign q2_in[g] = qp[SHIFT +: DAC_BITS];

      assign code_out[g] = zero2_ff[g] ? '0 : (sat2_ff[g] ? FULL_C : q2_ff[g]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= pair_in.ctl;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      level1_ff <= {pair_in.level_b, pair_in.level_a};
      prod1_ff  <= prod1_in;
      sat1_ff   <= sat1_in;
      zero1_ff  <= zero1_in;
      level2_ff <= level1_ff;
      q2_ff     <= q2_in;
      sat2_ff   <= sat1_ff;
      zero2_ff  <= zero1_ff;
   end

   assign ctl_out   = ctl2_ff;
   assign level_out = level2_ff;
   assign pending   = {1'b0, ctl1_ff.count} + {1'b0, ctl2_ff.count};

endmodule

`default_nettype wire

// File: hw/rtl/vws_queue.sv
// Output word queue: takes up to two words a cycle, hands out one.
// Depends on vws_pkg.
`default_nettype none

module vws_queue #(
   parameter int DAC_BITS = vws_pkg::DAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  vws_pkg::vws_ctl_type                wr_ctl,
   input  vws_pkg::vws_level_type [1:0]        wr_level,
   input  logic [1:0][DAC_BITS-1:0]            wr_code,
   input  logic                                pop,
   output logic                                head_valid,
   output vws_pkg::vws_level_type              head_level,
   output logic [DAC_BITS-1:0]                 head_code,
   output logic                                head_done,
   output logic                                head_last,
   output logic [vws_pkg::QUEUE_CNT_W-1:0]     fill
);
   import vws_pkg::*;

   vws_level_type       level_mem [QUEUE_DEPTH];
   logic [DAC_BITS-1:0] code_mem  [QUEUE_DEPTH];
   logic                done_mem  [QUEUE_DEPTH];
   logic                last_mem  [QUEUE_DEPTH];

   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in, wr_ptr_b;
   logic [QUEUE_CNT_W-1:0] fill_ff, fill_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      ptr_next = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : (p + QUEUE_PTR_W'(1));
   endfunction

   assign wr_ptr_b = ptr_next(wr_ptr_ff);

   always_comb begin
      case (wr_ctl.count)
         2'd1:    wr_ptr_in = wr_ptr_b;
         2'd2:    wr_ptr_in = ptr_next(wr_ptr_b);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + QUEUE_CNT_W'(wr_ctl.count) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.count != 2'd0) begin
         level_mem[wr_ptr_ff] <= wr_level[0];
         code_mem[wr_ptr_ff]  <= wr_code[0];
         done_mem[wr_ptr_ff]  <= wr_ctl.done;
         last_mem[wr_ptr_ff]  <= (wr_ctl.count == 2'd1);
      end
      if (wr_ctl.count == 2'd2) begin
         level_mem[wr_ptr_b] <= wr_level[1];
         code_mem[wr_ptr_b]  <= wr_code[1];
         done_mem[wr_ptr_b]  <= 1'b0;
         last_mem[wr_ptr_b]  <= 1'b1;
      end
   end

   assign head_valid = (fill_ff != '0);
   assign head_level = level_mem[rd_ptr_ff];
   assign head_code  = code_mem[rd_ptr_ff];
   assign head_done  = done_mem[rd_ptr_ff];
   assign head_last  = last_mem[rd_ptr_ff];
   assign fill       = fill_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vws_checker.sv
// Port-level checks for the voltammetry waveform sequencer, bound to the top level.
// Depends on vws_pkg and voltammetry_waveform_sequencer.
`default_nettype none

module vws_checker #(
   parameter int DAC_BITS = vws_pkg::DAC_BITS_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [vws_pkg::LEVEL_W-1:0] rsp_level_mv,
   input logic [DAC_BITS-1:0]                rsp_dac_code,
   input logic                               rsp_run_done,
   input logic                               rsp_last
);

   // Queue and pipeline come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("words or stall present right after reset");

   // End-of-run word is parked at zero and closes its request
   a_done_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_done |-> rsp_last && rsp_dac_code == '0 && rsp_level_mv == '0)
      else $error("end-of-run word malformed");

   // A new word reaches an empty queue only as the result of an earlier accepted request
   a_no_stray_word: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid && !req_stall, 3) |=> !rsp_valid)
      else $error("word appeared without a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_level_mv) &&
         $stable(rsp_dac_code) && $stable(rsp_run_done) && $stable(rsp_last))
      else $error("stalled word changed");

endmodule

bind voltammetry_waveform_sequencer vws_checker #(.DAC_BITS(DAC_BITS)) u_vws_checker (.*);

`default_nettype wire

// File: dv/vws_waveform_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the voltammetry waveform sequencer: mirrors the control registers,
// predicts every response word from the accepted request words and compares them.
// Depends on vws_pkg only; instantiated beside the block by the testbench top.

module vws_waveform_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_start_req,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [vws_pkg::LEVEL_W-1:0]   rsp_level_mv,
   input  logic [vws_pkg::DAC_BITS_DEFAULT-1:0] rsp_dac_code,
   input  logic                                 rsp_run_done,
   input  logic                                 rsp_last,
   input  logic                                 csr_write_en,
   input  logic [vws_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [vws_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output int                                   mismatch_count,
   output int                                   words_due,
   output int                                   words_checked,
   output int                                   runs_ended
);
   import vws_pkg::*;

   localparam longint DAC_FULL  = (64'd1 << DAC_BITS_DEFAULT) - 1;
   localparam longint DAC_SCALE = DAC_FULL / 5;

   typedef struct packed {
      logic signed [LEVEL_W-1:0]    level;
      logic [DAC_BITS_DEFAULT-1:0]  dac;
      logic                         done;
      logic                         last;
   } level_word_type;

   level_word_type due_levels[$];

   // register mirror
   logic [1:0]               cfg_mode;
   logic signed [MV_W-1:0]   cfg_start, cfg_end, cfg_va, cfg_vb;
   logic [STEP_W-1:0]        cfg_step, cfg_pulse;
   logic [CYCLE_W-1:0]       cfg_cycles;

   // run state
   logic        run_on;
   int unsigned leg;
   int          lvl;
   logic        up;
   int unsigned cyc_done;

   int bad, seen, ends;

   function automatic logic [DAC_BITS_DEFAULT-1:0] dac_code_of(input int mv);
      longint n;
      longint c;
      n = longint'(mv) * 10000 + 5619900;
      if (n < 0) return '0;
      c = n * DAC_SCALE / 3300000;
      if (c > DAC_FULL) c = DAC_FULL;
      return c[DAC_BITS_DEFAULT-1:0];
   endfunction

   function automatic void queue_level(input int mv, input logic is_last);
      level_word_type w;
      w.level = mv[LEVEL_W-1:0];
      w.dac   = dac_code_of(mv);
      w.done  = 1'b0;
      w.last  = is_last;
      due_levels.push_back(w);
   endfunction

   // end of run: DAC parked, level reads zero
   function automatic void close_run();
      level_word_type w;
      run_on = 1'b0;
      w = '0;
      w.done = 1'b1;
      w.last = 1'b1;
      due_levels.push_back(w);
   endfunction

   function automatic logic heading_to(input int target);
      return up ? (lvl < target) : (lvl > target);
   endfunction

   function automatic void advance_waveform(input logic is_start);
      int st, en, va, vb, stp, pul, target;
      st  = int'(cfg_start);
      en  = int'(cfg_end);
      va  = int'(cfg_va);
      vb  = int'(cfg_vb);
      stp = int'(cfg_step);
      pul = int'(cfg_pulse);
      if (is_start) begin
         lvl = st;
         cyc_done = 0;
         leg = 0;
         run_on = 1'b1;
         up = (cfg_mode == MODE_CYCLIC) ? (va > st) : (en > st);
         if (cfg_mode == MODE_SQUARE) queue_level(lvl, 1'b1);
         return;
      end
      if (!run_on) return;
      if (cfg_mode == MODE_SQUARE) begin
         if (!heading_to(en)) begin
            close_run();
            return;
         end
         lvl += up ? (pul + stp) : -(pul + stp);
         queue_level(lvl, 1'b0);
         lvl += up ? -pul : pul;
         queue_level(lvl, 1'b1);
         return;
      end
      if (cfg_mode != MODE_CYCLIC) begin
         if (!heading_to(en)) begin
            close_run();
            return;
         end
         queue_level(lvl, 1'b1);
         lvl += up ? stp : -stp;
         return;
      end
      // cyclic: empty legs fall through within the same step
      for (int guard = 0; guard < 1024; guard++) begin
         if (cyc_done >= cfg_cycles) begin
            close_run();
            return;
         end
         target = (leg == 0) ? va : (leg == 1) ? vb : en;
         if (heading_to(target)) begin
            queue_level(lvl, 1'b1);
            lvl += up ? stp : -stp;
            return;
         end
         leg++;
         if (leg >= 3) begin
            leg = 0;
            cyc_done = (cyc_done + 1) & 8'hFF;
            up = va > en;
            if (cyc_done == 0) begin
               close_run();
               return;
            end
         end else if (leg == 1) begin
            up = vb > va;
         end else begin
            up = en > vb;
         end
      end
      close_run();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_mode   = MODE_LINEAR;
         cfg_start  = '0;
         cfg_end    = '0;
         cfg_va     = '0;
         cfg_vb     = '0;
         cfg_step   = STEP_W'(1);
         cfg_pulse  = '0;
         cfg_cycles = CYCLE_W'(1);
         run_on     = 1'b0;
         leg        = 0;
         lvl        = 0;
         up         = 1'b0;
         cyc_done   = 0;
         bad        = 0;
         seen       = 0;
         ends       = 0;
         due_levels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_levels.size() == 0) begin
               bad++;
               $display("%0t unexpected word: expected none, got level_mv %0d dac_code %0d",
                        $time, rsp_level_mv, rsp_dac_code);
            end else begin
               level_word_type w;
               w = due_levels.pop_front();
               seen++;
               if (w.done) ends++;
               if (rsp_level_mv !== w.level) begin
                  bad++;
                  $display("%0t level_mv: expected %0d, got %0d", $time, w.level, rsp_level_mv);
               end
               if (rsp_dac_code !== w.dac) begin
                  bad++;
                  $display("%0t dac_code: expected %0d, got %0d", $time, w.dac, rsp_dac_code);
               end
               if (rsp_run_done !== w.done) begin
                  bad++;
                  $display("%0t run_done: expected %0b, got %0b", $time, w.done, rsp_run_done);
               end
               if (rsp_last !== w.last) begin
                  bad++;
                  $display("%0t last: expected %0b, got %0b", $time, w.last, rsp_last);
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_SWEEP_MODE:  cfg_mode   = csr_write_data[1:0];
               CSR_START_LEVEL: cfg_start  = csr_write_data[MV_W-1:0];
               CSR_END_LEVEL:   cfg_end    = csr_write_data[MV_W-1:0];
               CSR_VERTEX_A:    cfg_va     = csr_write_data[MV_W-1:0];
               CSR_VERTEX_B:    cfg_vb     = csr_write_data[MV_W-1:0];
               CSR_STEP:        cfg_step   = csr_write_data[STEP_W-1:0];
               CSR_PULSE:       cfg_pulse  = csr_write_data[STEP_W-1:0];
               CSR_CYCLE_COUNT: cfg_cycles = csr_write_data[CYCLE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) advance_waveform(req_start_req);
      end
      mismatch_count <= bad;
      words_due      <= due_levels.size();
      words_checked  <= seen;
      runs_ended     <= ends;
   end

endmodule

// File: dv/voltammetry_waveform_sequencer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the voltammetry waveform sequencer: clock, reset, register
// programming, request words and response stalls; verdict from vws_waveform_checker.
// Depends on vws_pkg, the block and dv/vws_waveform_checker.sv.

module voltammetry_waveform_sequencer_tb;
   import vws_pkg::*;

   localparam int LIMIT_NS      = 2_000_000;  // far above the slowest legal run
   localparam int SETTLE_CYCLES = 12;         // sequencer, DAC and queue pipe plus margin
   localparam int RANDOM_ITEMS  = 1450;

   // the spare mode code; the block runs it as a linear sweep
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid      = 1'b0;
   logic                          req_start_req  = 1'b0;
   logic                          rsp_stall      = 1'b0;
   logic                          csr_write_en   = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index      = '0;
   logic [CSR_DATA_W-1:0]         csr_write_data = '0;

   logic                          req_stall;
   logic                          rsp_valid;
   logic signed [LEVEL_W-1:0]     rsp_level_mv;
   logic [DAC_BITS_DEFAULT-1:0]   rsp_dac_code;
   logic                          rsp_run_done;
   logic                          rsp_last;

   int mismatch_count, words_due, words_checked, runs_ended;

   // idle rates, in percent: request gaps and response stalls
   int gap_pct   = 35;
   int stall_pct = 64;
   int items_sent = 0;
   int settings_loaded = 0;

   voltammetry_waveform_sequencer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_level_mv   (rsp_level_mv),
      .rsp_dac_code   (rsp_dac_code),
      .rsp_run_done   (rsp_run_done),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   vws_waveform_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_req  (req_start_req),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_level_mv   (rsp_level_mv),
      .rsp_dac_code   (rsp_dac_code),
      .rsp_run_done   (rsp_run_done),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .words_due      (words_due),
      .words_checked  (words_checked),
      .runs_ended     (runs_ended)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response back-pressure; redrawn every cycle so stalls land on any phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // One request word: random idle cycles first, then hold valid until taken.
   // Valid stays high on return, so back-to-back words never drop it.
   task automatic send_word(input logic start);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted word is back. A step or a start
   // may produce no word at all, so give the pipe its latency on top.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves the write enable high; load_waveform lowers it after the last one.
   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   // Writes all eight registers with the block idle. Bits above a register's
   // width carry junk, which the block must ignore.
   task automatic load_waveform(input vws_cfg_type w);
      logic [CSR_DATA_W-1:0] junk;
      settle();
      junk = CSR_DATA_W'($urandom);
      put_reg(CSR_SWEEP_MODE,  {junk[CSR_DATA_W-1:2], w.mode});
      put_reg(CSR_START_LEVEL, w.start_mv);
      put_reg(CSR_END_LEVEL,   w.end_mv);
      put_reg(CSR_VERTEX_A,    w.vertex_a_mv);
      put_reg(CSR_VERTEX_B,    w.vertex_b_mv);
      put_reg(CSR_STEP,        {junk[CSR_DATA_W-1:STEP_W], w.step_mv});
      junk = CSR_DATA_W'($urandom);
      put_reg(CSR_PULSE,       {junk[CSR_DATA_W-1:STEP_W], w.pulse_mv});
      put_reg(CSR_CYCLE_COUNT, {junk[CSR_DATA_W-1:CYCLE_W], w.cycles});
      csr_write_en <= 1'b0;
      settings_loaded++;
   endtask

   // A start word followed by step words
   task automatic run_steps(input int steps);
      send_word(1'b1);
      repeat (steps) send_word(1'b0);
   endtask

   // Mostly within the nominal +/-2000 mV; now and then any 12-bit code.
   function automatic logic signed [MV_W-1:0] pick_level();
      int v;
      if ($urandom_range(99) < 15) return MV_W'($urandom_range(4095));
      v = $urandom_range(4000);
      return MV_W'(v - 2000);
   endfunction

   function automatic vws_cfg_type pick_waveform();
      vws_cfg_type w;
      int r;
      r = $urandom_range(99);
      w.mode = (r < 30) ? MODE_LINEAR : (r < 65) ? MODE_CYCLIC :
               (r < 95) ? MODE_SQUARE : MODE_SPARE;
      w.start_mv    = pick_level();
      w.end_mv      = pick_level();
      w.vertex_a_mv = pick_level();
      w.vertex_b_mv = pick_level();
      // equal levels give empty legs and runs that end on the first step
      if ($urandom_range(99) < 15) w.vertex_a_mv = w.start_mv;
      if ($urandom_range(99) < 15) w.vertex_b_mv = w.vertex_a_mv;
      if ($urandom_range(99) < 10) w.end_mv = w.start_mv;
      // large steps keep most runs short; a zero step never finishes
      r = $urandom_range(99);
      w.step_mv = STEP_W'((r < 70) ? $urandom_range(1000, 150) :
                          (r < 94) ? $urandom_range(149, 1) :
                          (r < 97) ? 0 : $urandom_range(1023, 1001));
      w.pulse_mv = STEP_W'(($urandom_range(99) < 85) ? $urandom_range(1000) :
                                                       $urandom_range(1023));
      r = $urandom_range(99);
      w.cycles = CYCLE_W'((r < 55) ? $urandom_range(2, 1) : (r < 75) ? 0 :
                          (r < 95) ? $urandom_range(4, 3) : $urandom_range(255));
      return w;
   endfunction

   initial begin
      vws_cfg_type w;
      int base;
      int steps;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // step with no run: ignored
      send_word(1'b0);
      // reset settings: linear from 0 to 0 ends on the first step
      run_steps(1);

      // linear up across the full nominal span
      w = '0;
      w.mode = MODE_LINEAR;
      w.start_mv = MV_W'(-2000);
      w.end_mv = MV_W'(2000);
      w.step_mv = STEP_W'(1000);
      w.cycles = CYCLE_W'(1);
      load_waveform(w);
      run_steps(5);

      // square wave down, 1000 mV pulse
      w.mode = MODE_SQUARE;
      w.start_mv = MV_W'(2000);
      w.end_mv = MV_W'(-2000);
      w.pulse_mv = STEP_W'(1000);
      load_waveform(w);
      run_steps(5);

      // cyclic with no cycles: first step ends the run
      w = '0;
      w.mode = MODE_CYCLIC;
      w.step_mv = STEP_W'(1);
      w.cycles = '0;
      load_waveform(w);
      run_steps(1);

      // cyclic, cycle count register at 255: empty legs skipped within one step
      w.cycles = CYCLE_W'(255);
      load_waveform(w);
      run_steps(1);

      // spare mode code, widest field values
      w.mode = MODE_SPARE;
      w.start_mv = MV_W'(2047);
      w.end_mv = MV_W'(-2048);
      w.vertex_a_mv = MV_W'(-2048);
      w.vertex_b_mv = MV_W'(2047);
      w.step_mv = STEP_W'(1023);
      w.pulse_mv = STEP_W'(1023);
      load_waveform(w);
      run_steps(6);

      // ---- random part, three idling phases ----
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (items_sent - base >= 2 * RANDOM_ITEMS / 3) begin
            gap_pct = 0;
            stall_pct = 0;
         end else if (items_sent - base >= RANDOM_ITEMS / 3) begin
            gap_pct = 64;
            stall_pct = 35;
         end
         // most runs get fresh settings; some keep a live run across the gap
         if ($urandom_range(99) < 80) load_waveform(pick_waveform());
         steps = ($urandom_range(99) < 85) ? $urandom_range(30, 1) : $urandom_range(60, 31);
         // a few episodes are bare steps with no start
         if ($urandom_range(99) < 92) send_word(1'b1);
         repeat (steps) send_word($urandom_range(99) < 4);
      end

      settle();
      $display("Sent %0d request words across %0d register settings (all modes, restarts).",
               items_sent, settings_loaded);
      $display("Checked %0d response words, %0d of them end-of-run.", words_checked, runs_ended);
      if (mismatch_count == 0 && words_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #LIMIT_NS;
      $display("timeout with %0d response words outstanding", words_due);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
